// ===== sv/ccf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipped circle fill package
// Shared codes, constants and the store control bundle.
// ----------------------------------------------------------------------------
package ccf_pkg;

  // Operation codes carried by an input item.
  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Configuration register indexes.
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Reset values.
  localparam logic [6:0]  IMAGE_SIZE_RESET = 7'd64;
  localparam logic [31:0] OPAQUE_BLACK     = 32'h0000_00FF;

  // Control of the pixel store ports.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctrl_t;

endpackage

// ===== sv/clipped_circle_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipped circle fill
// RGBA pixel store with a clipped filled-circle draw, a pixel write and a
// pixel read.
//
// An item is taken at a rising edge with start_i high and busy_o low. Its
// single result appears on the result ports for one cycle with done_o high;
// the receiver cannot stall it. Configuration writes (cfg_we_i, cfg_idx_i,
// cfg_data_i) are taken at any edge and set the image size in use.
// A write, a read, an unused op or a rejected circle passes through the
// setup and finishing steps before done_o. A draw also walks the clipped
// bounding box row by row: the sequencer squares the row distance once per
// row and the column distance once per pixel, both through the one shared
// squaring unit. Each pixel write takes place in the cycle after its column
// distance is squared.
// After reset the block clears all MAX_WIDTH * MAX_HEIGHT pixels (4096 by
// default) to opaque black, one pixel per cycle, with busy_o high;
// configuration writes are taken during that pass.
// ----------------------------------------------------------------------------
module clipped_circle_fill #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int FRAC_BITS  = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [6:0]         cfg_data_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         op_i,
  input  logic signed [11:0] center_x_i,
  input  logic signed [11:0] center_y_i,
  input  logic [9:0]         radius_i,
  input  logic [5:0]         pixel_x_i,
  input  logic [5:0]         pixel_y_i,
  input  logic [31:0]        color_i,
  output logic               done_o,
  output logic [31:0]        read_color_o,
  output logic [5:0]         region_left_o,
  output logic [5:0]         region_top_o,
  output logic [6:0]         region_width_o,
  output logic [6:0]         region_height_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = ((6 + FRAC_BITS) > 11 ? (6 + FRAC_BITS) : 11) + 2;
  localparam int SQW   = 2 * (DW - 1);
  localparam int RND   = (1 << FRAC_BITS) - 1;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SETUP = 6'b000100,
    ST_ROW   = 6'b001000,
    ST_PIX   = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [6:0]         image_width_q, image_height_q;
  logic [6:0]         eff_w, eff_h;
  logic [AW-1:0]      clr_q;
  ccf_pkg::op_e       op_q;
  logic signed [11:0] cx_q, cy_q;
  logic [9:0]         r_q;
  logic [5:0]         pix_x_q, pix_y_q;
  logic [31:0]        color_q;
  logic               inside_q;
  logic [6:0]         x0_q, x1_q, y0_q, y1_q;
  logic [6:0]         px_q, py_q;
  logic               reject_q;
  logic [SQW-1:0]     r2_q, dy2_q, pend_sq_q;
  logic               pend_q;
  logic [AW-1:0]      pend_addr_q;
  logic               done_q;
  logic [31:0]        read_color_q;
  logic [5:0]         region_left_q, region_top_q;
  logic [6:0]         region_width_q, region_height_q;

  // Image size in use, limited to the store size.
  always_comb begin
    eff_w = (32'(image_width_q) > MAX_WIDTH) ? 7'(MAX_WIDTH) : image_width_q;
    eff_h = (32'(image_height_q) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : image_height_q;
  end

  // Bounding box of the latched circle, clipped to the image.
  logic signed [13:0] r_w, lo_x, hi_x, lo_y, hi_y;
  logic signed [13:0] fx0, fx1, fy0, fy1, x0c, x1c, y0c, y1c, wl, hl;
  logic               box_empty;

  always_comb begin
    r_w  = $signed({4'b0, r_q});
    lo_x = 14'(cx_q) - r_w;
    hi_x = 14'(cx_q) + r_w + 14'(RND);
    lo_y = 14'(cy_q) - r_w;
    hi_y = 14'(cy_q) + r_w + 14'(RND);
    fx0  = lo_x >>> FRAC_BITS;
    fx1  = hi_x >>> FRAC_BITS;
    fy0  = lo_y >>> FRAC_BITS;
    fy1  = hi_y >>> FRAC_BITS;
    wl   = $signed({7'b0, eff_w});
    hl   = $signed({7'b0, eff_h});
    x0c  = (fx0 < 14'sd0) ? 14'sd0 : fx0;
    y0c  = (fy0 < 14'sd0) ? 14'sd0 : fy0;
    x1c  = (fx1 > wl) ? wl : fx1;
    y1c  = (fy1 > hl) ? hl : fy1;
    box_empty = (x1c <= x0c) || (y1c <= y0c);
  end

  // Operand of the shared squaring unit for each step.
  logic signed [DW-1:0] sq_opnd;
  logic [SQW-1:0]       sq;

  always_comb begin
    case (state_q)
      ST_SETUP: sq_opnd = $signed(DW'(r_q));
      ST_ROW:   sq_opnd = ($signed(DW'(py_q)) <<< FRAC_BITS) - DW'(cy_q);
      ST_PIX:   sq_opnd = ($signed(DW'(px_q)) <<< FRAC_BITS) - DW'(cx_q);
      default:  sq_opnd = '0;
    endcase
  end

  ccf_sq_unit #(
    .DW (DW)
  ) u_sq (
    .opnd_i (sq_opnd),
    .sq_o   (sq)
  );

  // Addresses of the single pixel op and of the pixel being walked.
  logic [AW-1:0] pix_addr, walk_addr;
  logic          hit;
  logic          row_end, last_row;

  assign pix_addr  = AW'(pix_y_q) * AW'(MAX_WIDTH) + AW'(pix_x_q);
  assign walk_addr = AW'(py_q) * AW'(MAX_WIDTH) + AW'(px_q);
  assign hit       = ({1'b0, pend_sq_q} + {1'b0, dy2_q}) < {1'b0, r2_q};
  assign row_end   = (px_q == x1_q - 7'd1);
  assign last_row  = (py_q == y1_q - 7'd1);

  // Pixel store control.
  ccf_pkg::mem_ctrl_t mem_ctrl;
  logic [AW-1:0]      mem_waddr;
  logic [31:0]        mem_wdata;
  logic [31:0]        mem_rdata;

  always_comb begin
    mem_ctrl  = '0;
    mem_waddr = pend_addr_q;
    mem_wdata = color_q;
    if (state_q == ST_CLEAR) begin
      mem_ctrl.wr_en = 1'b1;
      mem_waddr      = clr_q;
      mem_wdata      = ccf_pkg::OPAQUE_BLACK;
    end else if (state_q == ST_SETUP) begin
      mem_waddr      = pix_addr;
      mem_ctrl.wr_en = (op_q == ccf_pkg::OP_WRITE) && inside_q;
      mem_ctrl.rd_en = (op_q == ccf_pkg::OP_READ) && inside_q;
    end else if (pend_q && hit) begin
      mem_ctrl.wr_en = 1'b1;
    end
  end

  ccf_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .ctrl_i  (mem_ctrl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (pix_addr),
    .rdata_o (mem_rdata)
  );

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        if (op_q == ccf_pkg::OP_DRAW && !box_empty) state_d = ST_ROW;
        else state_d = ST_FIN;
      end
      ST_ROW: state_d = ST_PIX;
      ST_PIX: begin
        if (row_end) state_d = last_row ? ST_FIN : ST_ROW;
      end
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      pend_q         <= 1'b0;
      done_q         <= 1'b0;
      image_width_q  <= ccf_pkg::IMAGE_SIZE_RESET;
      image_height_q <= ccf_pkg::IMAGE_SIZE_RESET;
    end else begin
      state_q <= state_d;
      pend_q  <= (state_q == ST_PIX);
      done_q  <= (state_q == ST_FIN);
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ccf_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i;
          ccf_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Item, walk and result registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_q     <= ccf_pkg::op_e'(op_i);
          cx_q     <= center_x_i;
          cy_q     <= center_y_i;
          r_q      <= radius_i;
          pix_x_q  <= pixel_x_i;
          pix_y_q  <= pixel_y_i;
          color_q  <= color_i;
          inside_q <= ({1'b0, pixel_x_i} < eff_w) && ({1'b0, pixel_y_i} < eff_h);
        end
      end
      ST_SETUP: begin
        r2_q     <= sq;
        reject_q <= box_empty;
        x0_q     <= 7'(x0c);
        x1_q     <= 7'(x1c);
        y0_q     <= 7'(y0c);
        y1_q     <= 7'(y1c);
        py_q     <= 7'(y0c);
      end
      ST_ROW: begin
        dy2_q <= sq;
        px_q  <= x0_q;
      end
      ST_PIX: begin
        pend_sq_q   <= sq;
        pend_addr_q <= walk_addr;
        px_q        <= px_q + 7'd1;
        if (row_end) py_q <= py_q + 7'd1;
      end
      ST_FIN: begin
        if (op_q == ccf_pkg::OP_READ && inside_q) begin
          read_color_q <= mem_rdata;
        end else begin
          read_color_q <= '0;
        end
        if (op_q == ccf_pkg::OP_DRAW && !reject_q) begin
          region_left_q   <= x0_q[5:0];
          region_top_q    <= y0_q[5:0];
          region_width_q  <= x1_q - x0_q;
          region_height_q <= y1_q - y0_q;
        end else begin
          region_left_q   <= '0;
          region_top_q    <= '0;
          region_width_q  <= '0;
          region_height_q <= '0;
        end
      end
      default: ;
    endcase
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign read_color_o    = read_color_q;
  assign region_left_o   = region_left_q;
  assign region_top_o    = region_top_q;
  assign region_width_o  = region_width_q;
  assign region_height_o = region_height_q;

  // A result strobe only follows the finishing step.
  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_FIN))
    else $error("result strobe without a finishing step");

  // An accepted item always enters the setup step.
  a_accept_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == ST_SETUP))
    else $error("accepted item did not enter setup");

  // The store is never written while the block is idle.
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_ctrl.wr_en)
    else $error("store written while idle");

  // The walk stays inside the clipped box.
  a_walk_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PIX) |-> ((px_q < x1_q) && (py_q < y1_q)))
    else $error("pixel walk left the clipped box");

endmodule

// ===== sv/ccf_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipped circle fill pixel store
// Single write port and one registered read port over the RGBA pixels.
// ----------------------------------------------------------------------------
module ccf_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic               clk_i,
  input  ccf_pkg::mem_ctrl_t ctrl_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [31:0]        wdata_i,
  input  logic [AW-1:0]      raddr_i,
  output logic [31:0]        rdata_o
);

  logic [31:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== sv/ccf_sq_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipped circle fill squaring unit
// Shared unit that squares the magnitude of a signed distance or radius.
// ----------------------------------------------------------------------------
module ccf_sq_unit #(
  parameter int DW = 13
) (
  input  logic signed [DW-1:0]     opnd_i,
  output logic [2*(DW-1)-1:0]      sq_o
);

  logic [DW-2:0] mag;

  // The operand never reaches the most negative code, so its magnitude fits.
  assign mag  = opnd_i[DW-1] ? (DW-1)'(-opnd_i) : opnd_i[DW-2:0];
  assign sq_o = mag * mag;

endmodule
